[sv/bpp_pkg.sv]
package bpp_pkg;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_IDLE  = 3'd1;
   localparam logic [2:0] MODE_CHG   = 3'd2;
   localparam logic [2:0] MODE_DSG   = 3'd3;
   localparam logic [2:0] MODE_WARN  = 3'd4;

   localparam logic [2:0] ERR_NONE = 3'd0;
   localparam logic [2:0] ERR_OC   = 3'd1;
   localparam logic [2:0] ERR_OV   = 3'd2;
   localparam logic [2:0] ERR_OCHG = 3'd3;
   localparam logic [2:0] ERR_ODSG = 3'd4;
   localparam logic [2:0] ERR_OT   = 3'd5;
   localparam logic [2:0] ERR_NP   = 3'd6;

   localparam logic [2:0] REG_RES   = 3'd0;
   localparam logic [2:0] REG_CHGOC = 3'd1;
   localparam logic [2:0] REG_DSGOC = 3'd2;
   localparam logic [2:0] REG_REV   = 3'd3;
   localparam logic [2:0] REG_OV    = 3'd4;
   localparam logic [2:0] REG_OT    = 3'd5;
   localparam logic [2:0] REG_FAN   = 3'd6;
   localparam logic [2:0] REG_LOSOC = 3'd7;

   localparam logic [2:0] RL_CHG_IN = 3'b001;
   localparam logic [2:0] RL_OUT    = 3'b110;
   localparam logic [2:0] LD_RED    = 3'b001;
   localparam logic [2:0] LD_GREEN  = 3'b010;
   localparam logic [2:0] LD_BLUE   = 3'b100;

   localparam int IN_W  = 118;
   localparam int OUT_W = 56;

   typedef struct packed {
      logic       charge_button;
      logic       inverter_button;
      logic       full_event;
      logic [14:0] voltage_mv;
      logic signed [17:0] current_ma;
      logic signed [8:0]  battery_temp_c;
      logic signed [8:0]  relay_temp_c;
      logic [6:0] soc_percent;
      logic [7:0] soc_cycle_byte;
      logic [15:0] cycle_count;
      logic       flash_valid;
      logic [31:0] flash_word;
   } item_type;

   typedef struct packed {
      logic [9:0]  res;
      logic [16:0] chg_oc;
      logic [16:0] dsg_oc;
      logic [16:0] rev;
      logic [14:0] ov;
      logic signed [8:0] ot;
      logic signed [8:0] fan;
      logic [6:0]  low_soc;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [6:0] est;
   } sts_type;

   // segment tables: bound[i] < uv <= bound[i+1]
   function automatic logic [23:0] seg_bound(input logic [2:0] i);
      case (i)
         3'd0: seg_bound = 24'd11200000;
         3'd1: seg_bound = 24'd12000000;
         3'd2: seg_bound = 24'd12800000;
         3'd3: seg_bound = 24'd13000000;
         3'd4: seg_bound = 24'd13168000;
         3'd5: seg_bound = 24'd13440000;
         3'd6: seg_bound = 24'd13760000;
         default: seg_bound = 24'd0;
      endcase
   endfunction

   function automatic logic [21:0] seg_slope(input logic [2:0] i);
      case (i)
         3'd0: seg_slope = 22'd25000;
         3'd1: seg_slope = 22'd90486;
         3'd2: seg_slope = 22'd500000;
         3'd3: seg_slope = 22'd1202500;
         3'd4: seg_slope = 22'd2419300;
         3'd5: seg_slope = 22'd125000;
         default: seg_slope = 22'd0;
      endcase
   endfunction

   function automatic logic [44:0] seg_offset(input logic [2:0] i);
      case (i)
         3'd0: seg_offset = 45'd280000000000;
         3'd1: seg_offset = 45'd1064800000000;
         3'd2: seg_offset = 45'd6300000000000;
         3'd3: seg_offset = 45'd15447000000000;
         3'd4: seg_offset = 45'd31562000000000;
         3'd5: seg_offset = 45'd720000000000;
         default: seg_offset = 45'd0;
      endcase
   endfunction

endpackage

[sv/bpp_datapath.sv]
module bpp_datapath (
   input  logic             clock,
   input  bpp_pkg::cmd_type cmd,
   input  bpp_pkg::item_type item,
   input  logic [9:0]       res,
   output bpp_pkg::sts_type sts
);

   logic signed [28:0] uv_ff, uv_in;
   logic signed [28:0] cr_ff;
   logic [2:0]  seg_ff, seg_in;
   logic [1:0]  cls_ff, cls_in;
   logic [45:0] num_ff;
   logic [6:0]  est_ff, est_in;
   logic signed [45:0] num_s;
   logic [60:0] qprod;
   logic [6:0]  q;
   logic [23:0] uvu;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cr_ff <= 29'(item.current_ma) * 29'($signed({1'b0, res}));
         uv_ff <= 29'(item.voltage_mv) * 29'sd1000;
      end
      if (cmd.mul1) begin
         uv_ff  <= uv_in;
      end
      if (cmd.mul2) begin
         seg_ff <= seg_in;
         cls_ff <= cls_in;
         num_ff <= num_s;
      end
      if (cmd.finish) begin
         est_ff <= est_in;
      end
   end

   assign uv_in = uv_ff + cr_ff;
   assign uvu   = uv_ff[23:0];

   always_comb begin
      seg_in = 3'd0;
      cls_in = 2'd0;
      if (uv_ff <= $signed({5'd0, bpp_pkg::seg_bound(3'd0)})) begin
         cls_in = 2'd1;
      end else if (uv_ff > $signed({5'd0, bpp_pkg::seg_bound(3'd6)})) begin
         cls_in = 2'd2;
      end else begin
         for (int i = 1; i < 6; i++) begin
            if (uvu > bpp_pkg::seg_bound(3'(i))) begin
               seg_in = 3'(i);
            end
         end
      end
      num_s = $signed({24'd0, bpp_pkg::seg_slope(seg_in)}) * $signed({22'd0, uvu})
            - $signed({1'b0, bpp_pkg::seg_offset(seg_in)});
   end

   // a positive numerator stays below 2^40; divide by 1024 then by 5^10 via reciprocal
   assign qprod = {31'd0, num_ff[39:10]} * 61'd1844674408;
   assign q     = qprod[60:54];

   always_comb begin
      case (cls_ff)
         2'd1: est_in = 7'd0;
         2'd2: est_in = 7'd100;
         default: begin
            if ($signed(num_ff) <= 0) begin
               est_in = 7'd0;
            end else if (q > 7'd100) begin
               est_in = 7'd100;
            end else begin
               est_in = q;
            end
         end
      endcase
   end

   assign sts.est = est_ff;

endmodule

[sv/bpp_control.sv]
module bpp_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bpp_pkg::item_type item,
   input  bpp_pkg::cfg_type  cfg,
   input  bpp_pkg::sts_type  sts,
   output bpp_pkg::cmd_type  cmd,
   output logic              done,
   output logic [55:0]       result
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_M1   = 3'd1;
   localparam logic [2:0] S_M2   = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;

   logic [2:0] st_ff, st_in;
   logic [2:0] mode_ff, mode_in, perr_ff, perr_in, rl_ff, rl_in, ld_ff, ld_in;
   logic [2:0] err;
   logic       sl, fw, rst;
   logic [6:0] sv, green;
   logic [31:0] fd;
   logic       exitf;
   logic signed [18:0] cur;

   assign cur = 19'(item.current_ma);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         mode_ff <= bpp_pkg::MODE_START;
         perr_ff <= bpp_pkg::ERR_NONE;
         rl_ff   <= 3'd0;
         ld_ff   <= 3'd0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_STEP) begin
            mode_ff <= mode_in;
            perr_ff <= perr_in;
            rl_ff   <= rl_in;
            ld_ff   <= ld_in;
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      cmd = '0;
      case (st_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            st_in = S_M1;
         end
         S_M1: begin
            cmd.mul1 = 1'b1;
            st_in = S_M2;
         end
         S_M2: begin
            cmd.mul2 = 1'b1;
            st_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            st_in = S_STEP;
         end
         S_STEP: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   assign done = (st_ff == S_STEP);

   always_comb begin
      mode_in = mode_ff;
      perr_in = perr_ff;
      rl_in = rl_ff;
      ld_in = ld_ff;
      err = bpp_pkg::ERR_NONE;
      sl = 1'b0;
      sv = 7'd0;
      rst = 1'b0;
      exitf = 1'b0;
      green = item.soc_percent;
      case (mode_ff)
         bpp_pkg::MODE_START: begin
            green = sts.est;
            rl_in = 3'd0;
            sl = 1'b1;
            sv = sts.est;
            if (item.flash_valid) begin
               sv = (item.flash_word[31:24] > 8'd100) ? 7'd100 : item.flash_word[30:24];
               rst = 1'b1;
               ld_in = ld_in | bpp_pkg::LD_BLUE;
            end
            mode_in = bpp_pkg::MODE_IDLE;
         end
         bpp_pkg::MODE_IDLE: begin
            ld_in = ld_in & ~bpp_pkg::LD_BLUE;
            if (item.charge_button && !item.inverter_button) begin
               rl_in = rl_in | bpp_pkg::RL_CHG_IN;
               mode_in = bpp_pkg::MODE_CHG;
            end
            if (!item.charge_button && item.inverter_button) begin
               rl_in = rl_in | bpp_pkg::RL_OUT;
               mode_in = bpp_pkg::MODE_DSG;
            end
         end
         bpp_pkg::MODE_CHG: begin
            if (item.soc_percent < 7'd95) begin
               ld_in = (ld_in | bpp_pkg::LD_RED) & ~bpp_pkg::LD_GREEN;
            end
            if (item.charge_button && !item.inverter_button) begin
               rl_in = rl_in & ~bpp_pkg::RL_CHG_IN;
               ld_in = ld_in & ~(bpp_pkg::LD_RED | bpp_pkg::LD_GREEN);
               exitf = 1'b1;
               mode_in = bpp_pkg::MODE_IDLE;
            end
            if (item.full_event) begin
               if (item.soc_percent > 7'd90) begin
                  sl = 1'b1;
                  sv = 7'd100;
               end else begin
                  mode_in = bpp_pkg::MODE_WARN;
                  perr_in = bpp_pkg::ERR_NP;
               end
            end
            if (cur < -$signed({2'b0, cfg.rev})) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_NP;
            end
            if (item.soc_percent >= 7'd100) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OCHG;
            end
            if (cur > $signed({2'b0, cfg.chg_oc})) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OC;
            end
            if (item.voltage_mv > cfg.ov) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OV;
            end
            if (item.battery_temp_c > cfg.ot) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OT;
            end
         end
         bpp_pkg::MODE_DSG: begin
            ld_in = ld_in | bpp_pkg::LD_BLUE;
            if (!item.charge_button && item.inverter_button) begin
               rl_in = rl_in & ~bpp_pkg::RL_OUT;
               exitf = 1'b1;
               mode_in = bpp_pkg::MODE_IDLE;
            end
            if (cur < -$signed({2'b0, cfg.dsg_oc})) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OC;
            end
            if (item.soc_percent < cfg.low_soc) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_ODSG;
            end
            if (item.battery_temp_c > cfg.ot) begin
               mode_in = bpp_pkg::MODE_WARN;
               perr_in = bpp_pkg::ERR_OT;
            end
         end
         bpp_pkg::MODE_WARN: begin
            rl_in = 3'd0;
            ld_in = ld_in & ~(bpp_pkg::LD_BLUE | bpp_pkg::LD_RED | bpp_pkg::LD_GREEN);
            err = perr_ff;
            perr_in = bpp_pkg::ERR_NONE;
            mode_in = bpp_pkg::MODE_IDLE;
         end
         default: mode_in = bpp_pkg::MODE_IDLE;
      endcase
      fw = exitf;
      fd = exitf ? {1'b0, item.soc_percent, item.soc_cycle_byte, item.cycle_count} : 32'd0;
      if (mode_in == bpp_pkg::MODE_WARN) begin
         err = perr_in;
      end
      if (green >= 7'd98) begin
         ld_in = ld_in | bpp_pkg::LD_GREEN;
      end else begin
         ld_in = ld_in & ~bpp_pkg::LD_GREEN;
      end
      result = {1'b0, rst, fd, fw, sv, sl, err,
                (item.relay_temp_c >= cfg.fan), ld_in, rl_in, mode_in};
   end

endmodule

[sv/bpp_regs.sv]
module bpp_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [16:0]      csr_data,
   output bpp_pkg::cfg_type cfg
);

   bpp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.res     <= 10'd50;
         cfg_ff.chg_oc  <= 17'd20000;
         cfg_ff.dsg_oc  <= 17'd40000;
         cfg_ff.rev     <= 17'd1000;
         cfg_ff.ov      <= 15'd15000;
         cfg_ff.ot      <= 9'sd50;
         cfg_ff.fan     <= 9'sd40;
         cfg_ff.low_soc <= 7'd10;
      end else if (csr_valid) begin
         case (csr_index)
            bpp_pkg::REG_RES:   cfg_ff.res     <= csr_data[9:0];
            bpp_pkg::REG_CHGOC: cfg_ff.chg_oc  <= csr_data;
            bpp_pkg::REG_DSGOC: cfg_ff.dsg_oc  <= csr_data;
            bpp_pkg::REG_REV:   cfg_ff.rev     <= csr_data;
            bpp_pkg::REG_OV:    cfg_ff.ov      <= csr_data[14:0];
            bpp_pkg::REG_OT:    cfg_ff.ot      <= csr_data[8:0];
            bpp_pkg::REG_FAN:   cfg_ff.fan     <= csr_data[8:0];
            bpp_pkg::REG_LOSOC: cfg_ff.low_soc <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/battery_pack_protection_fsm_core.sv]
// Battery pack mode controller. One request transaction is one control-loop pass and
// gives one response transaction. A pass runs five steps from acceptance to the response
// register (load, ocv sum, segment multiply, quotient, state update); the block takes the
// next request once the pass is done and the response register is free or being drained.
// Configuration writes take effect at once and are meant to happen while idle.
module battery_pack_protection_fsm_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [16:0]  csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // charge_button, inverter_button, full_event, voltage_mv, current_ma,
   // battery_temp_c, relay_temp_c, soc_percent, soc_cycle_byte, cycle_count,
   // flash_valid, flash_word, zero fill
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // mode, relays, leds, fan_on, error_code, soc_load, soc_value, flash_write,
   // flash_data, cycle_restore
   output logic [55:0]  rsp_tdata
);

   bpp_pkg::cfg_type  cfg;
   bpp_pkg::item_type item_ff;
   bpp_pkg::cmd_type  cmd;
   bpp_pkg::sts_type  sts;
   logic        busy_ff, busy_in, done, ov_ff;
   logic        cmd_started_ff;
   logic [55:0] res, out_ff;

   assign csr_ready = 1'b1;

   bpp_regs u_regs (
      .clock(clock), .reset(reset), .csr_valid(csr_valid),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   assign req_tready = !busy_ff && (!ov_ff || rsp_tready);
   assign busy_in = (req_tvalid && req_tready) ? 1'b1 : (done ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.charge_button   <= req_tdata[0];
         item_ff.inverter_button <= req_tdata[1];
         item_ff.full_event      <= req_tdata[2];
         item_ff.voltage_mv      <= req_tdata[17:3];
         item_ff.current_ma      <= req_tdata[35:18];
         item_ff.battery_temp_c  <= req_tdata[44:36];
         item_ff.relay_temp_c    <= req_tdata[53:45];
         item_ff.soc_percent     <= req_tdata[60:54];
         item_ff.soc_cycle_byte  <= req_tdata[68:61];
         item_ff.cycle_count     <= req_tdata[84:69];
         item_ff.flash_valid     <= req_tdata[85];
         item_ff.flash_word      <= req_tdata[117:86];
      end
      if (done) begin
         out_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (done) begin
            ov_ff <= 1'b1;
         end else if (rsp_tready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   bpp_datapath u_dp (
      .clock(clock), .cmd(cmd), .item(item_ff), .res(cfg.res), .sts(sts)
   );

   bpp_control u_ctl (
      .clock(clock), .reset(reset), .start(busy_ff && !cmd_started_ff),
      .item(item_ff), .cfg(cfg), .sts(sts), .cmd(cmd), .done(done), .result(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_started_ff <= 1'b0;
      end else if (done) begin
         cmd_started_ff <= 1'b0;
      end else if (cmd.load) begin
         cmd_started_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

endmodule

[tb/battery_pack_protection_fsm_core_tb.sv]
module battery_pack_protection_fsm_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        pad;
      logic        restore;
      logic [31:0] flash_data;
      logic        flash_write;
      logic [6:0]  soc_value;
      logic        soc_load;
      logic [2:0]  error_code;
      logic        fan_on;
      logic [2:0]  leds;
      logic [2:0]  relays;
      logic [2:0]  mode;
   } pass_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [16:0]  csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;

   // predictor state
   bpp_pkg::cfg_type pack_cfg;
   logic [2:0]   pack_mode;
   logic [2:0]   pack_pending_err;
   logic [2:0]   pack_relays;
   logic [2:0]   pack_leds;

   pass_result_type expected_passes[$];
   int unsigned  errors = 0;
   int unsigned  passes_checked = 0;
   int unsigned  warnings_seen = 0;
   int unsigned  flash_writes_seen = 0;
   bit           no_idle = 1'b0;
   bit           hold_rsp = 1'b0;
   int unsigned  stall_cycles = 0;

   always #2 clock = ~clock;

   battery_pack_protection_fsm_core u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic logic [6:0] ocv_soc_estimate(longint uv);
      longint bound[7] = '{11200000, 12000000, 12800000, 13000000, 13168000,
                           13440000, 13760000};
      longint slope[6] = '{25000, 90486, 500000, 1202500, 2419300, 125000};
      longint offs[6] = '{280000, 1064800, 6300000, 15447000, 31562000, 720000};
      longint num;
      longint q;
      if (uv <= bound[0]) return 7'd0;
      if (uv > bound[6]) return 7'd100;
      for (int i = 0; i < 6; i++) begin
         if (uv > bound[i] && uv <= bound[i+1]) begin
            num = slope[i] * uv - offs[i] * 64'sd1000000;
            if (num <= 0) return 7'd0;
            q = num / 64'sd10000000000;
            return (q > 100) ? 7'd100 : 7'(q);
         end
      end
      return 7'd0;
   endfunction

   function automatic pass_result_type predict_pass(bpp_pkg::item_type it);
      pass_result_type r;
      longint cur;
      longint bt;
      longint rt;
      longint ot;
      longint fan;
      logic [6:0] green_soc;
      logic [6:0] est;
      logic [7:0] fs;
      bit exit_hit;
      r = '0;
      cur = it.current_ma;
      bt = it.battery_temp_c;
      rt = it.relay_temp_c;
      ot = pack_cfg.ot;
      fan = pack_cfg.fan;
      green_soc = it.soc_percent;
      exit_hit = 0;
      case (pack_mode)
         bpp_pkg::MODE_START: begin
            est = ocv_soc_estimate(longint'(it.voltage_mv) * 1000 +
                                   cur * longint'(pack_cfg.res));
            green_soc = est;
            pack_relays = '0;
            r.soc_load = 1'b1;
            r.soc_value = est;
            if (it.flash_valid) begin
               fs = it.flash_word[31:24];
               r.soc_value = (fs > 100) ? 7'd100 : fs[6:0];
               r.restore = 1'b1;
               pack_leds |= bpp_pkg::LD_BLUE;
            end
            pack_mode = bpp_pkg::MODE_IDLE;
         end
         bpp_pkg::MODE_IDLE: begin
            pack_leds &= ~bpp_pkg::LD_BLUE;
            if (it.charge_button && !it.inverter_button) begin
               pack_relays |= bpp_pkg::RL_CHG_IN;
               pack_mode = bpp_pkg::MODE_CHG;
            end
            if (!it.charge_button && it.inverter_button) begin
               pack_relays |= bpp_pkg::RL_OUT;
               pack_mode = bpp_pkg::MODE_DSG;
            end
         end
         bpp_pkg::MODE_CHG: begin
            if (it.soc_percent < 95)
               pack_leds = (pack_leds | bpp_pkg::LD_RED) & ~bpp_pkg::LD_GREEN;
            if (it.charge_button && !it.inverter_button) begin
               pack_relays &= ~bpp_pkg::RL_CHG_IN;
               pack_leds &= ~(bpp_pkg::LD_RED | bpp_pkg::LD_GREEN);
               exit_hit = 1;
               pack_mode = bpp_pkg::MODE_IDLE;
            end
            if (it.full_event) begin
               if (it.soc_percent > 90) begin
                  r.soc_load = 1'b1;
                  r.soc_value = 7'd100;
               end else begin
                  pack_mode = bpp_pkg::MODE_WARN;
                  pack_pending_err = bpp_pkg::ERR_NP;
               end
            end
            if (cur < -longint'(pack_cfg.rev)) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_NP;
            end
            if (it.soc_percent >= 100) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OCHG;
            end
            if (cur > longint'(pack_cfg.chg_oc)) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OC;
            end
            if (it.voltage_mv > pack_cfg.ov) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OV;
            end
            if (bt > ot) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OT;
            end
         end
         bpp_pkg::MODE_DSG: begin
            pack_leds |= bpp_pkg::LD_BLUE;
            if (!it.charge_button && it.inverter_button) begin
               pack_relays &= ~bpp_pkg::RL_OUT;
               exit_hit = 1;
               pack_mode = bpp_pkg::MODE_IDLE;
            end
            if (cur < -longint'(pack_cfg.dsg_oc)) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OC;
            end
            if (it.soc_percent < pack_cfg.low_soc) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_ODSG;
            end
            if (bt > ot) begin
               pack_mode = bpp_pkg::MODE_WARN; pack_pending_err = bpp_pkg::ERR_OT;
            end
         end
         bpp_pkg::MODE_WARN: begin
            pack_relays = '0;
            pack_leds &= ~(bpp_pkg::LD_BLUE | bpp_pkg::LD_RED | bpp_pkg::LD_GREEN);
            r.error_code = pack_pending_err;
            pack_pending_err = bpp_pkg::ERR_NONE;
            pack_mode = bpp_pkg::MODE_IDLE;
         end
         default: pack_mode = bpp_pkg::MODE_IDLE;
      endcase
      if (exit_hit) begin
         r.flash_write = 1'b1;
         r.flash_data = {1'b0, it.soc_percent, it.soc_cycle_byte, it.cycle_count};
      end
      if (pack_mode == bpp_pkg::MODE_WARN) r.error_code = pack_pending_err;
      if (green_soc >= 98) pack_leds |= bpp_pkg::LD_GREEN;
      else pack_leds &= ~bpp_pkg::LD_GREEN;
      r.mode = pack_mode;
      r.relays = pack_relays;
      r.leds = pack_leds;
      r.fan_on = (rt >= fan);
      return r;
   endfunction

   function automatic logic [119:0] pack_item(bpp_pkg::item_type it);
      return {2'b00, it.flash_word, it.flash_valid, it.cycle_count, it.soc_cycle_byte,
              it.soc_percent, it.relay_temp_c, it.battery_temp_c, it.current_ma,
              it.voltage_mv, it.full_event, it.inverter_button, it.charge_button};
   endfunction

   function automatic bpp_pkg::item_type make_item(bit chg, bit inv, bit full, int volt,
                                                   int cur, int bt, int soc);
      bpp_pkg::item_type it;
      it.charge_button = chg;
      it.inverter_button = inv;
      it.full_event = full;
      it.voltage_mv = 15'(volt);
      it.current_ma = 18'(cur);
      it.battery_temp_c = 9'(bt);
      it.relay_temp_c = 9'($urandom_range(0, 190) - 40);
      it.soc_percent = 7'(soc);
      it.soc_cycle_byte = 8'($urandom);
      it.cycle_count = 16'($urandom);
      it.flash_valid = 1'($urandom_range(0, 1));
      it.flash_word = $urandom;
      return it;
   endfunction

   function automatic bpp_pkg::item_type random_item();
      int volt;
      int cur;
      int bt;
      int soc;
      volt = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 30000)
                                          : $urandom_range(11000, 14500);
      cur = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 40000)) - 20000
                                         : int'($urandom_range(0, 200000)) - 100000;
      bt = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 85)) - 40
                                        : int'($urandom_range(0, 190)) - 40;
      soc = ($urandom_range(0, 99) < 75) ? $urandom_range(15, 94) : $urandom_range(0, 100);
      return make_item($urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30,
                       $urandom_range(0, 99) < 10, volt, cur, bt, soc);
   endfunction

   task automatic send_item(bpp_pkg::item_type it);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_item(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_passes.push_back(predict_pass(it));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_passes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [16:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bpp_pkg::REG_RES:   pack_cfg.res = value[9:0];
         bpp_pkg::REG_CHGOC: pack_cfg.chg_oc = value;
         bpp_pkg::REG_DSGOC: pack_cfg.dsg_oc = value;
         bpp_pkg::REG_REV:   pack_cfg.rev = value;
         bpp_pkg::REG_OV:    pack_cfg.ov = value[14:0];
         bpp_pkg::REG_OT:    pack_cfg.ot = value[8:0];
         bpp_pkg::REG_FAN:   pack_cfg.fan = value[8:0];
         default:            pack_cfg.low_soc = value[6:0];
      endcase
      @(negedge clock);
   endtask

   task automatic load_thresholds(int res, int chg_oc, int dsg_oc, int rev, int ov,
                                  int ot, int fan, int low_soc);
      wait_drained();
      csr_write(bpp_pkg::REG_RES, 17'(res));
      csr_write(bpp_pkg::REG_CHGOC, 17'(chg_oc));
      csr_write(bpp_pkg::REG_DSGOC, 17'(dsg_oc));
      csr_write(bpp_pkg::REG_REV, 17'(rev));
      csr_write(bpp_pkg::REG_OV, 17'(ov));
      csr_write(bpp_pkg::REG_OT, 17'(ot));
      csr_write(bpp_pkg::REG_FAN, 17'(fan));
      csr_write(bpp_pkg::REG_LOSOC, 17'(low_soc));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_startup_pass();
      bpp_pkg::item_type it;
      it = make_item(1, 0, 1, 13760, 100000, 20, 50);
      it.flash_valid = 1'b1;
      it.flash_word = 32'hFF12_3456;
      send_item(it);
   endtask

   task automatic test_directed_modes();
      send_item(make_item(1, 1, 0, 12500, 0, 20, 50));        // both buttons, stay idle
      send_item(make_item(0, 0, 1, 12500, 0, 20, 50));        // full outside charge
      send_item(make_item(1, 0, 0, 12500, 5000, 20, 50));     // idle to charge
      send_item(make_item(0, 0, 1, 13500, 5000, 20, 93));     // full, soc loads 100
      send_item(make_item(0, 0, 0, 13500, 5000, 20, 98));     // green lit
      send_item(make_item(1, 0, 0, 13500, 5000, 20, 60));     // charge exit, flash write
      send_item(make_item(1, 0, 0, 12500, 5000, 20, 50));
      send_item(make_item(0, 0, 1, 12500, 5000, 20, 90));     // full with low soc
      send_item(make_item(0, 0, 0, 12500, 0, 20, 50));        // warning pass
      send_item(make_item(0, 1, 0, 12500, -5000, 20, 50));    // idle to discharge
      send_item(make_item(0, 1, 0, 12500, -5000, 20, 50));    // discharge exit
      send_item(make_item(0, 1, 0, 12500, -5000, 20, 50));
      send_item(make_item(0, 1, 0, 0, -100000, 150, 5));      // exit with protection hit
      send_item(make_item(0, 0, 0, 0, 0, -40, 0));
      send_item(make_item(1, 0, 0, 30000, 0, 20, 50));
      send_item(make_item(0, 0, 0, 30000, 100000, -40, 100)); // overvoltage wins
      send_item(make_item(0, 0, 0, 12500, 0, 20, 50));
      send_item(make_item(1, 0, 0, 12500, 0, 20, 50));
      send_item(make_item(0, 0, 0, 12500, -100000, 20, 100)); // reverse then overcharge
      send_item(make_item(0, 0, 0, 12500, 0, 20, 0));
      send_item(make_item(0, 1, 0, 12500, 0, 20, 127));
      send_item(make_item(0, 0, 0, 12500, -131072, 20, 50));
      send_item(make_item(0, 0, 0, 32767, 131071, 255, 50));
   endtask

   task automatic test_random_passes(int n);
      repeat (n) send_item(random_item());
   endtask

   task automatic test_rsp_backpressure();
      hold_rsp = 1'b1;
      repeat (12) send_item(random_item());
      hold_rsp = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_rsp && stall_cycles < 80) begin
         stall_cycles <= stall_cycles + 1;
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_rsp) stall_cycles <= 0;
         rsp_tready <= no_idle || hold_rsp || ($urandom_range(0, 99) >= 24);
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      pass_result_type got;
      pass_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_passes.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %0h", $time, rsp_tdata);
         end else begin
            want = expected_passes.pop_front();
            passes_checked++;
            if (want.mode == bpp_pkg::MODE_WARN) warnings_seen++;
            if (want.flash_write) flash_writes_seen++;
            check_field("mode", want.mode, got.mode);
            check_field("relays", want.relays, got.relays);
            check_field("leds", want.leds, got.leds);
            check_field("fan_on", want.fan_on, got.fan_on);
            check_field("error_code", want.error_code, got.error_code);
            check_field("soc_load", want.soc_load, got.soc_load);
            check_field("soc_value", want.soc_value, got.soc_value);
            check_field("flash_write", want.flash_write, got.flash_write);
            check_field("flash_data", want.flash_data, got.flash_data);
            check_field("cycle_restore", want.restore, got.restore);
            check_field("pad", 0, got.pad);
         end
      end
   end

   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      pack_cfg = '{res: 10'd50, chg_oc: 17'd20000, dsg_oc: 17'd40000, rev: 17'd1000,
                   ov: 15'd15000, ot: 9'sd50, fan: 9'sd40, low_soc: 7'd10};
      pack_mode = bpp_pkg::MODE_START;
      pack_pending_err = bpp_pkg::ERR_NONE;
      pack_relays = '0;
      pack_leds = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_startup_pass();
      test_directed_modes();
      test_random_passes(150);
      test_rsp_backpressure();
      wait_drained();
      load_thresholds($urandom_range(0, 1000), $urandom_range(0, 100000),
                      $urandom_range(0, 100000), $urandom_range(0, 100000),
                      $urandom_range(0, 30000), int'($urandom_range(0, 190)) - 40,
                      int'($urandom_range(0, 190)) - 40, $urandom_range(0, 100));
      no_idle = 1'b1;
      test_random_passes(120);
      no_idle = 1'b0;
      load_thresholds(0, 0, 0, 0, 0, -40, -40, 0);
      test_random_passes(100);
      load_thresholds(1000, 100000, 100000, 100000, 30000, 150, 150, 100);
      test_random_passes(100);
      load_thresholds(50, 20000, 40000, 1000, 15000, 50, 40, 10);
      test_random_passes(130);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("covered startup, all modes and protection checks over %0d passes",
               passes_checked);
      $display("%0d warning passes, %0d flash writes, five threshold sets",
               warnings_seen, flash_writes_seen);
      if (errors == 0 && expected_passes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[battery_pack_protection_fsm_core.f]
sv/bpp_pkg.sv
sv/bpp_datapath.sv
sv/bpp_control.sv
sv/bpp_regs.sv
sv/battery_pack_protection_fsm_core.sv
tb/battery_pack_protection_fsm_core_tb.sv
